@@ rtl/tup_pkg.sv @@
// Package for the text-to-unsigned parser.
// Holds character codes, digit offsets, parse phase and digit status types.
// No dependencies.
package tup_pkg;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_LO_X  = 8'h78;

    // letter value = code - (letter 'A' or 'a' - 10)
    localparam logic [7:0] UP_OFS   = 8'h37;
    localparam logic [7:0] LO_OFS   = 8'h57;

    localparam int        BASE_W    = 6;
    localparam logic [5:0] BASE_RST = 6'd10;
    localparam logic [5:0] BASE_8   = 6'd8;
    localparam logic [5:0] BASE_10  = 6'd10;
    localparam logic [5:0] BASE_16  = 6'd16;
    localparam logic [5:0] BASE_0   = 6'd0;

    typedef enum logic [5:0] {
        PH_DONE   = 6'b000001,
        PH_LEAD   = 6'b000010,
        PH_SIGNED = 6'b000100,
        PH_ZERO   = 6'b001000,
        PH_PREFIX = 6'b010000,
        PH_DIGITS = 6'b100000
    } t_phase;

    typedef enum logic [1:0] {
        ST_NONE = 2'd0,
        ST_SOME = 2'd1,
        ST_OVER = 2'd2
    } t_status;

endpackage

@@ rtl/text_to_unsigned_parser.sv @@
// Streaming text-to-unsigned parser (strtoul style), top level.
// Depends on tup_pkg.
//
// Usage:
//   Slave stream carries one character per transaction: tdata = ch,
//   tuser = start_req (1 marks the first character of a new string).
//   The config channel writes the 6-bit number base (0 = detect from
//   prefix); write it only while no string is in flight.
//   Master stream returns one transaction per terminated string, on the
//   first character that is not a valid digit. Characters after the
//   terminator and before the next start produce nothing.
//   The result is registered in the result register, or in the skid buffer
//   while the result register is held. Throughput: one character per cycle
//   while o_s_tready is high; the whole step (digit decode, one multiply-add
//   by the base, overflow compare) is combinational from the state registers.
//   Stall: a result register plus a one-entry skid buffer; o_s_tready drops
//   only while both hold a result.
//   Reset: phase waits for a start, base register returns to 10, both
//   output entries are emptied.
module text_to_unsigned_parser #(
    parameter int VALUE_WIDTH    = 32,
    parameter int POSITION_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [7:0]                    i_s_tdata,   // [7:0] ch
    input  logic                          i_s_tuser,   // [0] start_req
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [VW-1:0] value, [VW] overflow, [VW+1] any_digits, then end_offset
    output logic [((VALUE_WIDTH+POSITION_WIDTH+9)/8)*8-1:0] o_m_tdata,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tup_pkg::BASE_W-1:0]    i_cfg_data
);
    import tup_pkg::*;

    localparam int OUT_W = ((VALUE_WIDTH + POSITION_WIDTH + 9) / 8) * 8;
    localparam int MUL_W = VALUE_WIDTH + BASE_W + 1;

    logic [BASE_W-1:0]         r_number_base;
    t_phase                    r_phase, n_phase;
    logic [VALUE_WIDTH-1:0]    r_acc, n_acc;
    t_status                   r_status, n_status;
    logic [BASE_W-1:0]         r_base, n_base;
    logic [POSITION_WIDTH-1:0] r_pos, n_pos;

    logic                      r_out_valid, r_skid_valid;
    logic [OUT_W-1:0]          r_out_data, r_skid_data;

    logic                      v_first, v_digit, v_emit, v_alnum;
    logic [BASE_W-1:0]         v_d;
    logic [MUL_W-1:0]          v_prod;
    logic [OUT_W-1:0]          v_res;
    logic                      accept, res_new, out_free;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !r_skid_valid;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;
    assign accept      = i_s_tvalid && o_s_tready;
    assign res_new     = accept && v_emit;
    assign out_free    = !r_out_valid || i_m_tready;

    always_comb begin
        v_first  = 1'b0;
        v_digit  = 1'b0;
        v_emit   = 1'b0;
        v_alnum  = 1'b1;
        v_d      = '0;
        v_prod   = '0;
        v_res    = '0;
        if (i_s_tuser) begin
            n_phase  = PH_LEAD;
            n_acc    = '0;
            n_status = ST_NONE;
            n_base   = r_number_base;
            n_pos    = '0;
        end else begin
            n_phase  = r_phase;
            n_acc    = r_acc;
            n_status = r_status;
            n_base   = r_base;
            n_pos    = r_pos;
        end

        case (n_phase)
            PH_LEAD: begin
                if (i_s_tdata == CH_PLUS) begin
                    n_phase = PH_SIGNED;
                end else if (i_s_tdata != CH_SPACE) begin
                    v_first = 1'b1;
                end
            end
            PH_SIGNED: begin
                v_first = 1'b1;
            end
            PH_ZERO: begin
                if (i_s_tdata == CH_LO_X || i_s_tdata == CH_UP_X) begin
                    n_base  = BASE_16;
                    n_phase = PH_PREFIX;
                end else begin
                    if (n_base == BASE_0) n_base = BASE_8;
                    n_acc    = '0;
                    n_status = ST_SOME;
                    v_digit  = 1'b1;
                end
            end
            PH_PREFIX, PH_DIGITS: begin
                v_digit = 1'b1;
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase

        if (v_first) begin
            if ((n_base == BASE_0 || n_base == BASE_16) && i_s_tdata == CH_ZERO) begin
                n_phase = PH_ZERO;
            end else begin
                if (n_base == BASE_0) n_base = BASE_10;
                v_digit = 1'b1;
            end
        end

        if (i_s_tdata inside {[CH_ZERO:CH_NINE]}) begin
            v_d = BASE_W'(i_s_tdata - CH_ZERO);
        end else if (i_s_tdata inside {[CH_UP_A:CH_UP_Z]}) begin
            v_d = BASE_W'(i_s_tdata - UP_OFS);
        end else if (i_s_tdata inside {[CH_LO_A:CH_LO_Z]}) begin
            v_d = BASE_W'(i_s_tdata - LO_OFS);
        end else begin
            v_alnum = 1'b0;
        end
        v_prod = MUL_W'(n_acc) * MUL_W'(n_base) + MUL_W'(v_d);

        if (v_digit) begin
            if (!v_alnum || n_base == BASE_0 || v_d >= n_base) begin
                v_emit = 1'b1;
            end else begin
                if (n_status == ST_OVER || (|v_prod[MUL_W-1:VALUE_WIDTH])) begin
                    n_status = ST_OVER;
                end else begin
                    n_status = ST_SOME;
                    n_acc    = v_prod[VALUE_WIDTH-1:0];
                end
                n_phase = PH_DIGITS;
            end
        end

        if (v_emit) begin
            n_phase = PH_DONE;
            v_res[VALUE_WIDTH-1:0] = (n_status == ST_OVER) ? '1 : n_acc;
            v_res[VALUE_WIDTH]     = (n_status == ST_OVER);
            v_res[VALUE_WIDTH+1]   = (n_status != ST_NONE);
            v_res[VALUE_WIDTH+2 +: POSITION_WIDTH] = (n_status != ST_NONE) ? n_pos : '0;
        end

        if (n_phase != PH_DONE && n_pos != '1) begin
            n_pos = n_pos + POSITION_WIDTH'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number_base <= BASE_RST;
            r_phase       <= PH_DONE;
            r_acc         <= '0;
            r_status      <= ST_NONE;
            r_base        <= BASE_RST;
            r_pos         <= '0;
        end else begin
            if (i_cfg_valid) r_number_base <= i_cfg_data;
            if (accept) begin
                r_phase  <= n_phase;
                r_acc    <= n_acc;
                r_status <= n_status;
                r_base   <= n_base;
                r_pos    <= n_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= res_new;
            end
        end else if (res_new) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_data <= r_skid_valid ? r_skid_data : v_res;
        end
        if (res_new && !out_free) begin
            r_skid_data <= v_res;
        end
    end

endmodule
